// File: sv/ittu_pkg.sv
// ----------------------------------------------------------------------------
// ittu_pkg
// Shared types and constants for the I/O throughput throttle unit.
// ----------------------------------------------------------------------------
`default_nettype none

package ittu_pkg;

   localparam int TIME_BITS = 64;
   localparam int CFG_W     = 32;
   localparam int OP_W      = 2;
   localparam int IDX_W     = 2;
   localparam int BYTES_W   = 64;
   localparam int PROD_W    = 64;

   localparam logic [OP_W-1:0] OP_START    = 2'd0;
   localparam logic [OP_W-1:0] OP_COMPLETE = 2'd1;
   localparam logic [OP_W-1:0] OP_QUERY    = 2'd2;

   localparam logic [IDX_W-1:0] REG_BYTES_PER_MS = 2'd0;
   localparam logic [IDX_W-1:0] REG_BLOCK_SIZE   = 2'd1;
   localparam logic [IDX_W-1:0] REG_THINK_TIME   = 2'd2;
   localparam logic [IDX_W-1:0] REG_BURST_SIZE   = 2'd3;

   typedef logic [TIME_BITS-1:0] tstamp_type;

   typedef struct packed {
      logic [CFG_W-1:0] bytes_per_ms;
      logic [CFG_W-1:0] block_size;
      logic [CFG_W-1:0] think_time;
      logic [CFG_W-1:0] burst_size;
   } cfg_type;

   typedef struct packed {
      logic               throttle_query;
      logic [CFG_W-1:0]   sleep_ms;
      logic [PROD_W-1:0]  prod_lo;
      logic [PROD_W-1:0]  prod_hi;
      logic [BYTES_W-1:0] needed;
      logic               running;
   } mid_type;

endpackage : ittu_pkg

`default_nettype wire

// File: sv/ittu_csr.sv
// ----------------------------------------------------------------------------
// ittu_csr
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
`default_nettype none

module ittu_csr (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        csr_write_en,
   input  wire logic [ittu_pkg::IDX_W-1:0]  csr_index,
   input  wire logic [ittu_pkg::CFG_W-1:0]  csr_wdata,
   output ittu_pkg::cfg_type                cfg
);
   import ittu_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (csr_index)
            REG_BYTES_PER_MS: cfg_in.bytes_per_ms = csr_wdata;
            REG_BLOCK_SIZE:   cfg_in.block_size   = csr_wdata;
            REG_THINK_TIME:   cfg_in.think_time   = csr_wdata;
            REG_BURST_SIZE:   cfg_in.burst_size   = csr_wdata;
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule : ittu_csr

`default_nettype wire

// File: sv/ittu_core.sv
// ----------------------------------------------------------------------------
// ittu_core
// Input register, run state and first stage: mode decode, counters, deadline
// and the two partial products of the elapsed-time by rate check.
// ----------------------------------------------------------------------------
`default_nettype none

module ittu_core (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  ittu_pkg::cfg_type                  cfg,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [ittu_pkg::OP_W-1:0]     req_opcode,
   input  wire logic [63:0]                   req_now_ms,
   input  wire logic [ittu_pkg::CFG_W-1:0]    req_byte_count,
   output logic                               mid_valid,
   input  wire logic                          mid_ready,
   output ittu_pkg::mid_type                  mid
);
   import ittu_pkg::*;

   logic               in_valid_ff, in_valid_in;
   logic [OP_W-1:0]    op_ff;
   tstamp_type         now_ff;
   logic [CFG_W-1:0]   count_ff;

   tstamp_type         start_time_ff, start_time_in;
   logic [BYTES_W-1:0] bytes_done_ff, bytes_done_in;
   logic [CFG_W-1:0]   burst_count_ff, burst_count_in;
   tstamp_type         delay_until_ff, delay_until_in;
   logic               throttle_on_ff, throttle_on_in;
   logic               think_on_ff, think_on_in;
   logic               active_ff, active_in;
   logic [CFG_W-1:0]   lat_rate_ff, lat_rate_in;
   logic [CFG_W-1:0]   lat_block_ff, lat_block_in;
   logic [CFG_W-1:0]   lat_think_ff, lat_think_in;
   logic [CFG_W-1:0]   lat_burst_ff, lat_burst_in;

   logic               mid_valid_ff, mid_valid_in;
   mid_type            mid_ff, mid_in;

   logic               take_in, advance;
   tstamp_type         elapsed;
   logic [PROD_W-1:0]  elapsed_ext;
   logic [CFG_W-1:0]   burst_next;

   assign advance   = in_valid_ff && (!mid_valid_ff || mid_ready);
   assign req_ready = !in_valid_ff || advance;
   assign take_in   = req_valid && req_ready;

   assign in_valid_in  = take_in ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   assign mid_valid_in = advance ? 1'b1 : (mid_ready ? 1'b0 : mid_valid_ff);

   assign elapsed     = now_ff - start_time_ff;
   assign elapsed_ext = PROD_W'(elapsed);
   assign burst_next  = burst_count_ff + CFG_W'(1);

   always_comb begin
      start_time_in  = start_time_ff;
      bytes_done_in  = bytes_done_ff;
      burst_count_in = burst_count_ff;
      delay_until_in = delay_until_ff;
      throttle_on_in = throttle_on_ff;
      think_on_in    = think_on_ff;
      active_in      = active_ff;
      lat_rate_in    = lat_rate_ff;
      lat_block_in   = lat_block_ff;
      lat_think_in   = lat_think_ff;
      lat_burst_in   = lat_burst_ff;

      mid_in                = mid_ff;
      mid_in.throttle_query = 1'b0;
      mid_in.sleep_ms       = '0;
      mid_in.prod_lo        = PROD_W'(elapsed_ext[31:0]) * PROD_W'(lat_rate_ff);
      mid_in.prod_hi        = PROD_W'(elapsed_ext[63:32]) * PROD_W'(lat_rate_ff);
      mid_in.needed         = bytes_done_ff + BYTES_W'(lat_block_ff);

      if (advance) begin
         case (op_ff)
            OP_START: begin
               bytes_done_in  = '0;
               burst_count_in = '0;
               delay_until_in = '0;
               start_time_in  = now_ff;
               lat_block_in   = cfg.block_size;
               lat_rate_in    = '0;
               lat_think_in   = '0;
               lat_burst_in   = '0;
               throttle_on_in = 1'b0;
               think_on_in    = 1'b0;
               active_in      = 1'b0;
               if (cfg.bytes_per_ms != '0) begin
                  throttle_on_in = 1'b1;
                  lat_rate_in    = cfg.bytes_per_ms;
                  active_in      = 1'b1;
               end else if (cfg.think_time != '0) begin
                  think_on_in  = 1'b1;
                  lat_think_in = cfg.think_time;
                  lat_burst_in = cfg.burst_size;
                  active_in    = 1'b1;
               end
            end
            OP_COMPLETE: begin
               bytes_done_in  = bytes_done_ff + BYTES_W'(count_ff);
               burst_count_in = burst_next;
               if (think_on_ff && (burst_next >= lat_burst_ff)) begin
                  burst_count_in = '0;
                  delay_until_in = now_ff + TIME_BITS'(lat_think_ff);
               end
            end
            OP_QUERY: begin
               if (think_on_ff && (now_ff < delay_until_ff)) begin
                  mid_in.sleep_ms = CFG_W'(delay_until_ff - now_ff);
               end else if (throttle_on_ff) begin
                  mid_in.throttle_query = 1'b1;
               end
            end
            default: begin
               mid_in.sleep_ms = '0;
            end
         endcase
      end
      mid_in.running = active_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         mid_valid_ff   <= 1'b0;
         start_time_ff  <= '0;
         bytes_done_ff  <= '0;
         burst_count_ff <= '0;
         delay_until_ff <= '0;
         throttle_on_ff <= 1'b0;
         think_on_ff    <= 1'b0;
         active_ff      <= 1'b0;
         lat_rate_ff    <= '0;
         lat_block_ff   <= '0;
         lat_think_ff   <= '0;
         lat_burst_ff   <= '0;
      end else begin
         in_valid_ff    <= in_valid_in;
         mid_valid_ff   <= mid_valid_in;
         start_time_ff  <= start_time_in;
         bytes_done_ff  <= bytes_done_in;
         burst_count_ff <= burst_count_in;
         delay_until_ff <= delay_until_in;
         throttle_on_ff <= throttle_on_in;
         think_on_ff    <= think_on_in;
         active_ff      <= active_in;
         lat_rate_ff    <= lat_rate_in;
         lat_block_ff   <= lat_block_in;
         lat_think_ff   <= lat_think_in;
         lat_burst_ff   <= lat_burst_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take_in) begin
         op_ff    <= req_opcode;
         now_ff   <= req_now_ms[TIME_BITS-1:0];
         count_ff <= req_byte_count;
      end
      if (advance) begin
         mid_ff <= mid_in;
      end
   end

   assign mid_valid = mid_valid_ff;
   assign mid       = mid_ff;

endmodule : ittu_core

`default_nettype wire

// File: sv/ittu_resp.sv
// ----------------------------------------------------------------------------
// ittu_resp
// Second stage: saturating sum of the partial products, compare against the
// byte target and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module ittu_resp (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        mid_valid,
   output logic                             mid_ready,
   input  ittu_pkg::mid_type                mid,
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output logic [ittu_pkg::CFG_W-1:0]       rsp_sleep_ms,
   output logic                             rsp_running
);
   import ittu_pkg::*;

   logic              out_valid_ff, out_valid_in;
   logic [CFG_W-1:0]  sleep_ff, sleep_in;
   logic              running_ff;
   logic [PROD_W-1:0] top;
   logic [PROD_W:0]   sum;
   logic              saturate;
   logic [PROD_W-1:0] expected;
   logic              take;

   assign mid_ready    = !out_valid_ff || rsp_ready;
   assign take         = mid_valid && mid_ready;
   assign out_valid_in = take ? 1'b1 : (rsp_ready ? 1'b0 : out_valid_ff);

   assign top      = {mid.prod_hi[31:0], 32'd0};
   assign sum      = {1'b0, top} + {1'b0, mid.prod_lo};
   assign saturate = (mid.prod_hi[63:32] != '0) || sum[PROD_W];
   assign expected = saturate ? '1 : sum[PROD_W-1:0];

   always_comb begin
      sleep_in = mid.sleep_ms;
      if (mid.throttle_query) begin
         sleep_in = (expected >= mid.needed) ? '0 : CFG_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         sleep_ff   <= sleep_in;
         running_ff <= mid.running;
      end
   end

   assign rsp_valid    = out_valid_ff;
   assign rsp_sleep_ms = sleep_ff;
   assign rsp_running  = running_ff;

endmodule : ittu_resp

`default_nettype wire

// File: sv/io_throughput_throttle_unit.sv
// ----------------------------------------------------------------------------
// io_throughput_throttle_unit
// Paces I/O issue from start, completion and sleep-query transactions.
// ----------------------------------------------------------------------------
// One transaction is taken per clock unless the receiver stalls, and each gives
// exactly one result. After the input register, the first stage updates the run
// state and forms the two 32x32 partial products of elapsed time by rate, and the
// second stage adds them with saturation and compares against completed plus
// block bytes. Configuration writes take effect at the next start transaction.
`default_nettype none

module io_throughput_throttle_unit (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_ready,
   input  wire logic [ittu_pkg::OP_W-1:0]   req_opcode,
   input  wire logic [63:0]                 req_now_ms,
   input  wire logic [ittu_pkg::CFG_W-1:0]  req_byte_count,
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output logic [ittu_pkg::CFG_W-1:0]       rsp_sleep_ms,
   output logic                             rsp_running,
   input  wire logic                        csr_write_en,
   input  wire logic [ittu_pkg::IDX_W-1:0]  csr_index,
   input  wire logic [ittu_pkg::CFG_W-1:0]  csr_wdata
);
   import ittu_pkg::*;

   cfg_type cfg;
   mid_type mid;
   logic    mid_valid;
   logic    mid_ready;

   ittu_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .cfg          (cfg)
   );

   ittu_core u_core (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_opcode     (req_opcode),
      .req_now_ms     (req_now_ms),
      .req_byte_count (req_byte_count),
      .mid_valid      (mid_valid),
      .mid_ready      (mid_ready),
      .mid            (mid)
   );

   ittu_resp u_resp (
      .clock        (clock),
      .reset        (reset),
      .mid_valid    (mid_valid),
      .mid_ready    (mid_ready),
      .mid          (mid),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_sleep_ms (rsp_sleep_ms),
      .rsp_running  (rsp_running)
   );

endmodule : io_throughput_throttle_unit

`default_nettype wire

// File: sv/ittu_checker.sv
// ----------------------------------------------------------------------------
// ittu_checker
// Port-level checks on the throttle unit, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ittu_checker (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   input  wire logic                        req_ready,
   input  wire logic                        rsp_valid,
   input  wire logic                        rsp_ready,
   input  wire logic [ittu_pkg::CFG_W-1:0]  rsp_sleep_ms,
   input  wire logic                        rsp_running
);
   import ittu_pkg::*;

   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_sleep_ms) && $stable(rsp_running))
      else $error("result changed while stalled");

   a_reset_empty : assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_idle_no_sleep : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_running |-> rsp_sleep_ms == '0)
      else $error("nonzero sleep while not running");

   a_ready_after_drain : assert property (@(posedge clock) disable iff (reset)
      !rsp_valid ##1 !rsp_valid ##1 !rsp_valid |-> req_ready || !req_valid)
      else $error("request blocked with empty pipeline");

endmodule : ittu_checker

bind io_throughput_throttle_unit ittu_checker u_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_valid),
   .req_ready    (req_ready),
   .rsp_valid    (rsp_valid),
   .rsp_ready    (rsp_ready),
   .rsp_sleep_ms (rsp_sleep_ms),
   .rsp_running  (rsp_running)
);

`default_nettype wire

// File: bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for io_throughput_throttle_unit. A short table of start,
// completion and query transactions hits reset state, saturation, time wrap and
// unused opcode behavior. Random runs in throttle, think and idle modes follow.
// Every result is checked against a table answer or a local pacing model, with
// random gaps and stalls on both channels and one long receiver hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
   import ittu_pkg::*;

   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
   localparam int RANDOM_ITEMS    = 1530;
   localparam int HOLD_OFF_CYCLES = 200;
   localparam int DRAIN_LIMIT     = 5000;

   typedef struct packed {
      logic [CFG_W-1:0] sleep_ms;
      logic             running;
   } pace_answer_type;

   typedef enum logic {ROW_ITEM, ROW_CSR} row_kind_type;

   typedef struct {
      row_kind_type      kind;
      logic [OP_W-1:0]   op;
      logic [63:0]       now;
      logic [CFG_W-1:0]  cnt;
      logic              known;
      pace_answer_type   ans;
      logic [IDX_W-1:0]  idx;
   } plan_row_type;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   logic [OP_W-1:0]   req_opcode;
   logic [63:0]       req_now_ms;
   logic [CFG_W-1:0]  req_byte_count;
   logic              rsp_valid;
   logic              rsp_ready;
   logic [CFG_W-1:0]  rsp_sleep_ms;
   logic              rsp_running;
   logic              csr_write_en;
   logic [IDX_W-1:0]  csr_index;
   logic [CFG_W-1:0]  csr_wdata;

   io_throughput_throttle_unit u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_opcode     (req_opcode),
      .req_now_ms     (req_now_ms),
      .req_byte_count (req_byte_count),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_sleep_ms   (rsp_sleep_ms),
      .rsp_running    (rsp_running),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   pace_answer_type due_answers[$];
   pace_answer_type oldest;
   plan_row_type    plan[$];
   int              fault_count = 0;
   logic            steady = 1'b0;
   logic            hold_off_req = 1'b0;

   cfg_type            cfg_live;
   logic [CFG_W-1:0]   run_rate, run_block, run_think, run_burst;
   tstamp_type         start_time, delay_until;
   logic [BYTES_W-1:0] bytes_done;
   logic [31:0]        burst_count;
   logic               throttle_on, think_on, active;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #4_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   task automatic log_fault(input string msg);
      fault_count++;
      $display("ERROR at %0t: %s", $time, msg);
   endtask

   function automatic int idle_draw();
      return steady ? 0 : int'($urandom_range(0, 11));
   endfunction

   function automatic logic [31:0] stretch32(input logic [31:0] narrow);
      case ($urandom_range(0, 15))
         0, 1: return $urandom;
         2:    return '1;
         default: return narrow;
      endcase
   endfunction

   function automatic void plan_item(input logic [OP_W-1:0] op, input logic [63:0] now,
                                     input logic [CFG_W-1:0] cnt, input logic known,
                                     input logic [CFG_W-1:0] sleep_ms, input logic running);
      plan_row_type row;
      row.kind = ROW_ITEM;
      row.op = op;
      row.now = now;
      row.cnt = cnt;
      row.known = known;
      row.ans.sleep_ms = sleep_ms;
      row.ans.running = running;
      row.idx = '0;
      plan.push_back(row);
   endfunction

   function automatic void plan_csr(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
      plan_row_type row;
      row.kind = ROW_CSR;
      row.op = OP_START;
      row.now = '0;
      row.cnt = val;
      row.known = 1'b0;
      row.ans = '0;
      row.idx = idx;
      plan.push_back(row);
   endfunction

   task automatic pace_predict(input logic [OP_W-1:0] op, input logic [63:0] now_in,
                               input logic [CFG_W-1:0] cnt, output pace_answer_type ans);
      tstamp_type         now;
      tstamp_type         span;
      logic [95:0]        wide_span, wide_rate, prod;
      logic [63:0]        paced;
      logic [BYTES_W-1:0] needed;
      now = now_in[TIME_BITS-1:0];
      ans.sleep_ms = '0;
      case (op)
         OP_START: begin
            bytes_done = '0;
            burst_count = '0;
            delay_until = '0;
            start_time = now;
            run_block = cfg_live.block_size;
            run_rate = '0;
            run_think = '0;
            run_burst = '0;
            throttle_on = 1'b0;
            think_on = 1'b0;
            active = 1'b0;
            if (cfg_live.bytes_per_ms != '0) begin
               throttle_on = 1'b1;
               run_rate = cfg_live.bytes_per_ms;
               active = 1'b1;
            end else if (cfg_live.think_time != '0) begin
               think_on = 1'b1;
               run_think = cfg_live.think_time;
               run_burst = cfg_live.burst_size;
               active = 1'b1;
            end
         end
         OP_COMPLETE: begin
            bytes_done = bytes_done + cnt;
            burst_count = burst_count + 1;
            if (think_on && burst_count >= run_burst) begin
               burst_count = '0;
               delay_until = now + run_think;
            end
         end
         OP_QUERY: begin
            if (think_on && now < delay_until) begin
               span = delay_until - now;
               ans.sleep_ms = span[31:0];
            end else if (throttle_on) begin
               span = now - start_time;
               wide_span = span;
               wide_rate = run_rate;
               prod = wide_span * wide_rate;
               paced = (prod[95:64] != '0) ? '1 : prod[63:0];
               needed = bytes_done + run_block;
               ans.sleep_ms = (paced >= needed) ? 32'd0 : 32'd1;
            end
         end
         default: ;
      endcase
      ans.running = active;
   endtask

   task automatic send_item(input logic [OP_W-1:0] op, input logic [63:0] now,
                            input logic [CFG_W-1:0] cnt, input logic known,
                            input pace_answer_type given);
      int              gap;
      pace_answer_type ans;
      gap = idle_draw();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_opcode <= op;
      req_now_ms <= now;
      req_byte_count <= cnt;
      do @(posedge clock); while (!req_ready);
      pace_predict(op, now, cnt, ans);
      due_answers.push_back(known ? given : ans);
      @(negedge clock);
   endtask

   task automatic drain_results();
      int waited;
      req_valid <= 1'b0;
      waited = 0;
      while (due_answers.size() != 0 && waited < DRAIN_LIMIT) begin
         @(negedge clock);
         waited++;
      end
      repeat (4) @(negedge clock);
   endtask

   task automatic csr_write(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         REG_BYTES_PER_MS: cfg_live.bytes_per_ms = val;
         REG_BLOCK_SIZE:   cfg_live.block_size = val;
         REG_THINK_TIME:   cfg_live.think_time = val;
         REG_BURST_SIZE:   cfg_live.burst_size = val;
         default: ;
      endcase
      @(negedge clock);
      csr_write_en <= 1'b0;
      @(negedge clock);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (due_answers.size() == 0)
            log_fault($sformatf("unexpected transaction sleep_ms=%0d running=%0b",
                                rsp_sleep_ms, rsp_running));
         else begin
            oldest = due_answers.pop_front();
            if (rsp_sleep_ms !== oldest.sleep_ms)
               log_fault($sformatf("sleep_ms got %0d want %0d",
                                   rsp_sleep_ms, oldest.sleep_ms));
            if (rsp_running !== oldest.running)
               log_fault($sformatf("running got %0b want %0b",
                                   rsp_running, oldest.running));
         end
      end
   end

   initial begin : rsp_side
      int stall;
      rsp_ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            stall = HOLD_OFF_CYCLES;
         end else
            stall = idle_draw();
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
         @(negedge clock);
      end
   end

   initial begin : req_side
      int               item_total, mode, n, k, sel, tick_max;
      logic             pressured;
      logic [31:0]      rate, block, think, burst, cnt_max;
      logic [63:0]      clock_ms, step;
      reset = 1'b1;
      req_valid = 1'b0;
      req_opcode = OP_START;
      req_now_ms = '0;
      req_byte_count = '0;
      csr_write_en = 1'b0;
      csr_index = REG_BYTES_PER_MS;
      csr_wdata = '0;
      cfg_live = '0;
      run_rate = '0;
      run_block = '0;
      run_think = '0;
      run_burst = '0;
      start_time = '0;
      delay_until = '0;
      bytes_done = '0;
      burst_count = '0;
      throttle_on = 1'b0;
      think_on = 1'b0;
      active = 1'b0;
      pressured = 1'b0;

      plan_item(OP_QUERY, 64'd0, 32'd0, 1'b1, 32'd0, 1'b0);
      plan_item(OP_COMPLETE, 64'd5, '1, 1'b1, 32'd0, 1'b0);
      plan_item(OP_UNUSED, '1, '1, 1'b1, 32'd0, 1'b0);
      plan_item(OP_START, 64'd10, 32'd0, 1'b1, 32'd0, 1'b0);
      plan_item(OP_QUERY, 64'd20, 32'd0, 1'b1, 32'd0, 1'b0);
      plan_csr(REG_BYTES_PER_MS, '1);
      plan_csr(REG_BLOCK_SIZE, '1);
      plan_item(OP_START, 64'd100, 32'd0, 1'b1, 32'd0, 1'b1);
      plan_item(OP_QUERY, 64'd100, 32'd0, 1'b1, 32'd1, 1'b1);
      plan_item(OP_QUERY, '1, 32'd0, 1'b1, 32'd0, 1'b1);
      plan_item(OP_COMPLETE, 64'd200, '1, 1'b1, 32'd0, 1'b1);
      plan_item(OP_QUERY, 64'd300, 32'd0, 1'b0, 32'd0, 1'b0);
      plan_item(OP_UNUSED, 64'd300, 32'd5, 1'b1, 32'd0, 1'b1);
      plan_csr(REG_BYTES_PER_MS, 32'd0);
      plan_csr(REG_THINK_TIME, '1);
      plan_csr(REG_BURST_SIZE, 32'd0);
      plan_item(OP_START, 64'hFFFF_FFFF_FFFF_FFF0, 32'd0, 1'b1, 32'd0, 1'b1);
      plan_item(OP_COMPLETE, 64'hFFFF_FFFF_FFFF_FFF0, 32'd0, 1'b1, 32'd0, 1'b1);
      plan_item(OP_QUERY, 64'hFFFF_FFFF_FFFF_FFF8, 32'd0, 1'b0, 32'd0, 1'b0);
      plan_item(OP_QUERY, 64'd5, 32'd0, 1'b0, 32'd0, 1'b0);
      plan_csr(REG_THINK_TIME, 32'd3);
      plan_csr(REG_BURST_SIZE, 32'd2);
      plan_item(OP_QUERY, 64'd6, 32'd0, 1'b0, 32'd0, 1'b0);
      plan_item(OP_START, 64'd1000, 32'd0, 1'b1, 32'd0, 1'b1);
      plan_item(OP_COMPLETE, 64'd1001, 32'd7, 1'b0, 32'd0, 1'b0);
      plan_item(OP_COMPLETE, 64'd1002, 32'd9, 1'b0, 32'd0, 1'b0);
      plan_item(OP_QUERY, 64'd1003, 32'd0, 1'b0, 32'd0, 1'b0);
      plan_item(OP_QUERY, 64'd1005, 32'd0, 1'b0, 32'd0, 1'b0);
      plan_csr(REG_THINK_TIME, 32'd0);
      plan_csr(REG_BLOCK_SIZE, 32'd0);
      plan_item(OP_START, 64'd2000, 32'd0, 1'b1, 32'd0, 1'b0);
      plan_item(OP_COMPLETE, 64'd2001, 32'd4, 1'b1, 32'd0, 1'b0);
      plan_item(OP_QUERY, 64'd2002, 32'd0, 1'b1, 32'd0, 1'b0);

      repeat (9) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (plan[i]) begin
         if (plan[i].kind == ROW_CSR) begin
            drain_results();
            csr_write(plan[i].idx, plan[i].cnt);
         end else
            send_item(plan[i].op, plan[i].now, plan[i].cnt, plan[i].known, plan[i].ans);
      end

      item_total = 0;
      while (item_total < RANDOM_ITEMS) begin
         drain_results();
         mode = $urandom_range(0, 9);
         steady = ($urandom_range(0, 3) == 0);
         n = $urandom_range(20, 60);
         if (!pressured && item_total > 600) begin
            steady = 1'b1;
            hold_off_req = 1'b1;
            pressured = 1'b1;
            n = 60;
         end
         rate = 32'd0;
         block = stretch32($urandom_range(0, 4000));
         think = stretch32($urandom_range(0, 40));
         burst = stretch32($urandom_range(0, 6));
         tick_max = 3;
         if (mode < 4) begin
            rate = stretch32($urandom_range(1, 2000));
            tick_max = 1;
         end else if (mode < 8) begin
            if (think == 32'd0)
               think = 32'd1;
         end else if (mode == 8) begin
            think = 32'd0;
         end else begin
            rate = $urandom;
            block = $urandom;
            think = $urandom;
            burst = $urandom;
         end
         csr_write(REG_BYTES_PER_MS, rate);
         csr_write(REG_BLOCK_SIZE, block);
         csr_write(REG_THINK_TIME, think);
         csr_write(REG_BURST_SIZE, burst);
         cnt_max = (rate != 32'd0 && rate < 32'd4096) ? 2 * rate : 32'd3000;

         case ($urandom_range(0, 3))
            0: clock_ms = {$urandom, $urandom};
            1: clock_ms = 64'hFFFF_FFFF_FFFF_FFFF - $urandom_range(0, 150);
            default: clock_ms = $urandom_range(0, 100000);
         endcase

         send_item(OP_START, clock_ms, $urandom, 1'b0, '0);
         item_total++;
         for (k = 0; k < n; k++) begin
            sel = $urandom_range(0, 99);
            if ($urandom_range(0, 15) == 0)
               step = $urandom_range(0, 1000);
            else
               step = $urandom_range(0, tick_max);
            clock_ms = clock_ms + step;
            if (sel < 40)
               send_item(OP_COMPLETE, clock_ms, stretch32($urandom_range(0, cnt_max)),
                         1'b0, '0);
            else if (sel < 85)
               send_item(OP_QUERY, clock_ms, $urandom, 1'b0, '0);
            else if (sel < 90)
               send_item(OP_START, clock_ms, $urandom, 1'b0, '0);
            else if (sel < 94)
               send_item(OP_UNUSED, {$urandom, $urandom}, $urandom, 1'b0, '0);
            else if (sel < 97)
               send_item(OP_W'($urandom_range(0, 3)), {$urandom, $urandom}, $urandom,
                         1'b0, '0);
            else begin
               drain_results();
               csr_write(IDX_W'($urandom_range(0, 3)), stretch32($urandom_range(0, 50)));
               continue;
            end
            item_total++;
         end
      end

      drain_results();
      repeat (10) @(negedge clock);
      if (due_answers.size() != 0)
         log_fault($sformatf("%0d expected transactions never arrived",
                             due_answers.size()));
      if (fault_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

// File: sim.f
sv/ittu_pkg.sv
sv/ittu_csr.sv
sv/ittu_core.sv
sv/ittu_resp.sv
sv/io_throughput_throttle_unit.sv
sv/ittu_checker.sv
bench/tb.sv
